FILE: rtl/core/ffba_pkg.sv
// Shared types, codes and defaults of the first-fit block allocator.
package ffba_pkg;

    localparam int DEFAULT_MAX_BLOCKS   = 64;
    localparam int DEFAULT_HEADER_BYTES = 40;

    localparam logic [31:0] HEAP_LENGTH_RESET = 32'd1048576;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] STATUS_REUSED    = 3'd0;
    localparam logic [2:0] STATUS_APPENDED  = 3'd1;
    localparam logic [2:0] STATUS_NO_MEMORY = 3'd2;
    localparam logic [2:0] STATUS_FREED     = 3'd3;
    localparam logic [2:0] STATUS_IGNORED   = 3'd4;

    // Configuration register indexes.
    localparam int          CFG_IDX_W       = 1;
    localparam logic [0:0]  CFG_HEAP_BASE   = 1'b0;
    localparam logic [0:0]  CFG_HEAP_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One row of the block table.
    typedef struct packed {
        logic        used;
        logic [31:0] bytes;
        logic [31:0] start;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit_hit;
        logic commit_miss;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/ffba_datapath.sv
// Datapath of the allocator: block table memory, scan pointer, heap bookkeeping, result stage.
module ffba_datapath #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEFAULT_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEFAULT_HEADER_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffba_pkg::ctrl_cmd_t cmd,
    output ffba_pkg::ctrl_sts_t sts,
    input  logic                req_op,
    input  logic [31:0]         req_size,
    input  logic [63:0]         req_address,
    input  logic [63:0]         heap_base,
    input  logic [31:0]         heap_length,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          m_tuser,
    output logic [63:0]         m_tdata
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    ffba_pkg::entry_t mem [MAX_BLOCKS];

    logic                 op_reg;
    logic [31:0]          size_reg;
    logic [63:0]          key_reg;
    logic [CNT_W-1:0]     scan_idx_reg;
    logic                 pipe_v_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    ffba_pkg::entry_t     rd_entry_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [32:0]          heap_end_reg;
    logic [2:0]           res_status_reg;
    logic [31:0]          res_start_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [63:0]          out_addr_reg;

    logic                 alloc_fit;
    logic                 free_fit;
    logic                 issue;
    logic [33:0]          need;
    logic                 append_ok;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    ffba_pkg::entry_t     mem_wdata;
    logic                 grants_addr;

    assign alloc_fit = !rd_entry_reg.used && (rd_entry_reg.bytes >= size_reg);
    assign free_fit  = rd_entry_reg.used && ({32'd0, rd_entry_reg.start} == key_reg);

    assign sts.hit       = pipe_v_reg && ((op_reg == ffba_pkg::OP_ALLOC) ? alloc_fit : free_fit);
    assign sts.exhausted = !pipe_v_reg && (scan_idx_reg >= count_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign issue = cmd.scan && (scan_idx_reg < count_reg);

    assign need      = {1'b0, heap_end_reg} + 34'(HEADER_BYTES) + {2'd0, size_reg};
    assign append_ok = (count_reg != CNT_W'(MAX_BLOCKS)) && (need <= {2'd0, heap_length});

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = rd_entry_reg;
        if (cmd.commit_hit) begin
            mem_we         = 1'b1;
            mem_wdata.used = !rd_entry_reg.used;
        end else if (cmd.commit_miss && (op_reg == ffba_pkg::OP_ALLOC) && append_ok) begin
            mem_we          = 1'b1;
            mem_waddr       = count_reg[IDX_W-1:0];
            mem_wdata.used  = 1'b1;
            mem_wdata.bytes = size_reg;
            mem_wdata.start = heap_end_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_entry_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg   <= scan_idx_reg[IDX_W-1:0];
        end
    end

    // Request latch; the free key is the header offset that the address implies.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= req_op;
            size_reg <= req_size;
            key_reg  <= req_address - heap_base - 64'(HEADER_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            pipe_v_reg   <= 1'b0;
        end else if (cmd.load) begin
            scan_idx_reg <= '0;
            pipe_v_reg   <= 1'b0;
        end else if (cmd.scan) begin
            pipe_v_reg <= issue;
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
        end else begin
            pipe_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            heap_end_reg <= 33'(HEADER_BYTES);
        end else if (cmd.commit_miss && (op_reg == ffba_pkg::OP_ALLOC) && append_ok) begin
            count_reg    <= count_reg + CNT_W'(1);
            heap_end_reg <= need[32:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_hit) begin
            res_status_reg <= (op_reg == ffba_pkg::OP_ALLOC) ? ffba_pkg::STATUS_REUSED
                                                             : ffba_pkg::STATUS_FREED;
            res_start_reg  <= rd_entry_reg.start;
        end else if (cmd.commit_miss) begin
            res_start_reg <= heap_end_reg[31:0];
            if (op_reg == ffba_pkg::OP_FREE) begin
                res_status_reg <= ffba_pkg::STATUS_IGNORED;
            end else if (append_ok) begin
                res_status_reg <= ffba_pkg::STATUS_APPENDED;
            end else begin
                res_status_reg <= ffba_pkg::STATUS_NO_MEMORY;
            end
        end
    end

    assign grants_addr = (res_status_reg == ffba_pkg::STATUS_REUSED) ||
                         (res_status_reg == ffba_pkg::STATUS_APPENDED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= grants_addr ?
                              (heap_base + {32'd0, res_start_reg} + 64'(HEADER_BYTES)) : 64'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_addr_reg;

endmodule

FILE: rtl/core/ffba_controller.sv
// Controller state machine of the allocator: accept, table scan, result hand-off.
module ffba_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ffba_pkg::ctrl_sts_t sts,
    output ffba_pkg::ctrl_cmd_t cmd
);

    ffba_pkg::state_t state_reg;
    ffba_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffba_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ffba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ffba_pkg::ST_SCAN;
                end
            end
            ffba_pkg::ST_SCAN: begin
                if (sts.hit) begin
                    cmd.commit_hit = 1'b1;
                    state_next     = ffba_pkg::ST_FINISH;
                end else if (sts.exhausted) begin
                    cmd.commit_miss = 1'b1;
                    state_next      = ffba_pkg::ST_FINISH;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ffba_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ffba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: configuration registers and core wiring.
// A request is accepted in idle; the scan then reads table entries in order up to the first
// fit, or up to block_count on a miss, and the result is committed and handed to the output
// register. One request at a time: the next is accepted only after that hand-off; the scan
// walks the single read port of the block table memory one entry per cycle.
// Reset: the table starts empty (block_count zero), heap_end holds one header size, and no
// clearing pass is needed since only entries below block_count are ever read.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEFAULT_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEFAULT_HEADER_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [63:0]                   cfg_wr_data,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tuser,  // [0] op
    input  logic [95:0]                   s_tdata,  // [31:0] request_size, [95:32] free_address
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2:0]                    m_tuser,  // [2:0] status
    output logic [63:0]                   m_tdata   // [63:0] data_address
);

    logic [63:0] heap_base_reg;
    logic [31:0] heap_length_reg;

    ffba_pkg::ctrl_cmd_t cmd;
    ffba_pkg::ctrl_sts_t sts;

    // Configuration must only be written while no request is in flight; the user keeps to this, as
    // the block has no guard for it, so the datapath may read these registers directly at any point of a request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg   <= 64'd0;
            heap_length_reg <= ffba_pkg::HEAP_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ffba_pkg::CFG_HEAP_BASE: begin
                    heap_base_reg <= cfg_wr_data;
                end
                ffba_pkg::CFG_HEAP_LENGTH: begin
                    heap_length_reg <= cfg_wr_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The controller sequences accept, scan, commit and result hand-off.
    ffba_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the block table, the heap end and the output register. A finished
    // result sits in the output register while the controller returns to idle and takes the
    // next request beat.
    ffba_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .req_op      (s_tuser),
        .req_size    (s_tdata[31:0]),
        .req_address (s_tdata[95:32]),
        .heap_base   (heap_base_reg),
        .heap_length (heap_length_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

endmodule
